// ----- rtl/core/bss_pkg.sv -----
package bss_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int POS_W     = 32;
	localparam int NEEDLE_W  = 64;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT  = 2'd2;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_IDLE      = 2'd3
	} status_t;

	// input word after classification
	typedef struct packed {
		logic [BYTE_W-1:0] hay_byte;
		logic              first;
		logic              is_zero;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [POS_W-1:0]  match_position;
	} result_t;

	typedef struct packed {
		logic [NEEDLE_W-1:0] needle_bytes;
		logic [LEN_W-1:0]    needle_length;
		logic [POS_W-1:0]    search_limit;
	} cfg_t;

endpackage

// ----- rtl/core/bss_fifo.sv -----
module bss_fifo #(
	parameter int WIDTH = 8,
	parameter int AW    = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_q;
	logic [AW:0]      rd_q;

	// extra pointer bit tells full from empty
	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign rdata = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[AW-1:0]] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/bss_front.sv -----
module bss_front #(
	parameter int IN_AW = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [bss_pkg::BYTE_W-1:0]    hay_byte,
	input  logic                          first,
	input  logic                          item_pop,
	output bss_pkg::item_t                item,
	output logic                          item_empty
);

	import bss_pkg::*;

	item_t                 item_in;
	logic [$bits(item_t)-1:0] item_raw;

	// classify on entry so the back end sees the end-of-string flag ready-made
	always_comb begin
		item_in.hay_byte = hay_byte;
		item_in.first    = first;
		item_in.is_zero  = (hay_byte == '0);
	end

	bss_fifo #(
		.WIDTH ($bits(item_t)),
		.AW    (IN_AW)
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item_in),
		.full   (full),
		.pop    (item_pop),
		.rdata  (item_raw),
		.empty  (item_empty)
	);

	assign item = item_t'(item_raw);

endmodule

// ----- rtl/core/bss_back.sv -----
module bss_back #(
	parameter int NEEDLE_MAX = 8,
	parameter int OUT_AW     = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bss_pkg::cfg_t    cfg,
	input  bss_pkg::item_t   item,
	input  logic             item_empty,
	output logic             item_pop,
	input  logic             pop,
	output logic             empty,
	output bss_pkg::result_t result
);

	import bss_pkg::*;

	// window keeps the previous NEEDLE_MAX-1 bytes, newest in the low byte
	localparam int WIN_W  = BYTE_W * (NEEDLE_MAX - 1);
	localparam int FULL_W = WIN_W + BYTE_W;

	logic [WIN_W-1:0] recent_q;
	logic [POS_W-1:0] pos_q;
	logic             finished_q;

	logic [WIN_W-1:0]  recent_eff, recent_d;
	logic [POS_W-1:0]  pos_eff, pos_d;
	logic              fin_eff, fin_d;
	logic [FULL_W-1:0] win_full;
	logic [LEN_W-1:0]  len_clip, eff_len;
	logic [NEEDLE_MAX:1] len_hit;
	logic              hit;
	logic [POS_W:0]    pos_inc;
	logic              at_limit, last_pos, len_fits;
	logic              out_full, fire;
	result_t           res;
	logic [$bits(result_t)-1:0] res_raw;

	// needle length, clipped and cut at the first zero character
	always_comb begin
		len_clip = (cfg.needle_length > LEN_W'(NEEDLE_MAX)) ?
			LEN_W'(NEEDLE_MAX) : cfg.needle_length;
		eff_len = len_clip;
		for (int m = NEEDLE_MAX - 1; m >= 0; m--) begin
			if ((LEN_W'(m) < len_clip) && (cfg.needle_bytes[BYTE_W*m +: BYTE_W] == '0)) begin
				eff_len = LEN_W'(m);
			end
		end
	end

	// restart clears state before the word is handled
	assign recent_eff = item.first ? '0 : recent_q;
	assign pos_eff    = item.first ? '0 : pos_q;
	assign fin_eff    = item.first ? 1'b0 : finished_q;

	assign win_full = {recent_eff, item.hay_byte};

	// one match flag per candidate length, newest byte lines up with the last needle char
	always_comb begin
		for (int l = 1; l <= NEEDLE_MAX; l++) begin
			len_hit[l] = 1'b1;
			for (int m = 0; m < l; m++) begin
				if (win_full[BYTE_W*(l-1-m) +: BYTE_W] !=
				    cfg.needle_bytes[BYTE_W*m +: BYTE_W]) begin
					len_hit[l] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int l = 1; l <= NEEDLE_MAX; l++) begin
			if (eff_len == LEN_W'(l)) begin
				hit = len_hit[l];
			end
		end
	end

	assign pos_inc  = {1'b0, pos_eff} + 1'b1;
	assign len_fits = (pos_inc >= (POS_W+1)'(eff_len));
	assign at_limit = (pos_eff >= cfg.search_limit);
	assign last_pos = (pos_inc >= {1'b0, cfg.search_limit});

	always_comb begin
		res.status         = ST_SEARCHING;
		res.match_position = '0;
		fin_d              = fin_eff;
		pos_d              = pos_eff;
		recent_d           = recent_eff;
		if (fin_eff) begin
			res.status = ST_IDLE;
		end else if (eff_len == '0) begin
			res.status = ST_FOUND;
			fin_d      = 1'b1;
		end else if (at_limit || item.is_zero) begin
			res.status = ST_NOT_FOUND;
			fin_d      = 1'b1;
		end else begin
			recent_d = win_full[WIN_W-1:0];
			if (hit && len_fits) begin
				res.status         = ST_FOUND;
				res.match_position = pos_eff - POS_W'(eff_len) + 1'b1;
				fin_d              = 1'b1;
			end else if (last_pos) begin
				res.status = ST_NOT_FOUND;
				fin_d      = 1'b1;
			end else begin
				pos_d = pos_inc[POS_W-1:0];
			end
		end
	end

	assign fire     = !item_empty && !out_full;
	assign item_pop = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			pos_q      <= '0;
			finished_q <= 1'b1;
		end else if (fire) begin
			recent_q   <= recent_d;
			pos_q      <= pos_d;
			finished_q <= fin_d;
		end
	end

	bss_fifo #(
		.WIDTH ($bits(result_t)),
		.AW    (OUT_AW)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.wdata  (res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_raw),
		.empty  (empty)
	);

	assign result = result_t'(res_raw);

endmodule

// ----- rtl/core/bounded_substring_search.sv -----
// Path: a pushed word is written into the input queue, then passes through the
//   search engine, which writes its status word into the result queue.
// Throughput: one word per cycle; the engine retires one word per cycle whenever
//   the input queue holds a word and the result queue has room.
// Reset (arst_n low, asynchronous): both queues empty, configuration zero, search
//   marked finished so every word reports idle until one arrives with first set.
module bounded_substring_search #(
	parameter int NEEDLE_MAX = 8,
	parameter int IN_AW      = 2,
	parameter int OUT_AW     = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// haystack side
	input  logic                              push,
	output logic                              full,
	input  logic [bss_pkg::BYTE_W-1:0]        hay_byte,
	input  logic                              first,
	// result side
	input  logic                              pop,
	output logic                              empty,
	output bss_pkg::status_t                  status,
	output logic [bss_pkg::POS_W-1:0]         match_position,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bss_pkg::NEEDLE_W-1:0]      cfg_data
);

	import bss_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	logic    item_empty;
	logic    item_pop;
	result_t result;

	// The user must change configuration only while the block is idle; the block
	// does not enforce it. The engine reads these registers directly, with no shadow copy.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NEEDLE_BYTES:  cfg_q.needle_bytes  <= cfg_data;
				REG_NEEDLE_LENGTH: cfg_q.needle_length <= cfg_data[LEN_W-1:0];
				REG_SEARCH_LIMIT:  cfg_q.search_limit  <= cfg_data[POS_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// Front end: takes haystack words, flags the zero byte, and queues them.
	bss_front #(
		.IN_AW (IN_AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hay_byte   (hay_byte),
		.first      (first),
		.item_pop   (item_pop),
		.item       (item),
		.item_empty (item_empty)
	);

	// Back end: holds the byte window, position and finished flag, compares
	// the needle against every candidate length in parallel, and queues one
	// status word per haystack word.
	bss_back #(
		.NEEDLE_MAX (NEEDLE_MAX),
		.OUT_AW     (OUT_AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign status         = result.status;
	assign match_position = result.match_position;

endmodule

// ----- rtl/core/bss_checker.sv -----
module bss_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          pop,
	input logic                          empty,
	input bss_pkg::status_t              status,
	input logic [bss_pkg::POS_W-1:0]     match_position
);

	import bss_pkg::*;

	// held result word stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(match_position)))
		else $error("result word changed while stalled");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_FOUND) |-> (match_position == '0))
		else $error("nonzero position without a match");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not empty in reset");

	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("input queue filled with no push");

endmodule

bind bounded_substring_search bss_checker u_bss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.push           (push),
	.full           (full),
	.pop            (pop),
	.empty          (empty),
	.status         (status),
	.match_position (match_position)
);
